// ===== rtl/core/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("Assertion failed in %m.");

// Checks that a condition implies another condition in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("Assertion failed in %m.");

`endif

// ===== rtl/core/lfxr_pkg.sv =====
// Package with the constants and types of the lagged Fibonacci xor generator.
`default_nettype none

package lfxr_pkg;

  localparam int unsigned WORD_W = 32;
  localparam int unsigned RING_DEPTH = 256;
  localparam int unsigned IDX_W = $clog2(RING_DEPTH);

  localparam logic [WORD_W-1:0] LCG_MUL = WORD_W'(67397);
  localparam logic [WORD_W-1:0] LCG_ADD = WORD_W'(7364893);
  localparam logic [WORD_W-1:0] SEED_RESET = WORD_W'(1);

  localparam logic [IDX_W-1:0] LAG_A = IDX_W'(24);
  localparam logic [IDX_W-1:0] LAG_B = IDX_W'(55);
  localparam logic [IDX_W-1:0] LAG_C = IDX_W'(61);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_FILL,
    ST_IDLE,
    ST_RD_A,
    ST_RD_B,
    ST_RD_C,
    ST_WR
  } state_e;

  typedef enum logic [1:0] {
    LAG_SEL_A,
    LAG_SEL_B,
    LAG_SEL_C
  } lag_sel_e;

  typedef struct packed {
    logic     load;
    logic     fill;
    lag_sel_e rd_sel;
    logic     cap_a;
    logic     cap_sum;
    logic     draw;
  } ctrl_cmd_t;

  typedef struct packed {
    logic fill_last;
    logic out_free;
  } dp_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/lfxr_ifs.sv =====
// Valid/ready channel interfaces for the input and result beats.
`default_nettype none

interface lfxr_in_if;
  logic valid;
  logic ready;
  logic reseed;

  modport source (output valid, output reseed, input ready);
  modport sink (input valid, input reseed, output ready);
endinterface

interface lfxr_out_if;
  logic                        valid;
  logic                        ready;
  logic [lfxr_pkg::WORD_W-1:0] random_word;

  modport source (output valid, output random_word, input ready);
  modport sink (input valid, input random_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/lfxr_ram.sv =====
// Generic RAM with one write port and one registered read port.
`default_nettype none

module lfxr_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/lfxr_ctrl.sv =====
// Controller state machine that sequences ring fills and draws.
`default_nettype none

module lfxr_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 in_reseed_i,
  output logic                      in_ready_o,
  input  wire lfxr_pkg::dp_status_t status_i,
  output lfxr_pkg::ctrl_cmd_t       cmd_o
);

  lfxr_pkg::state_e state_q, state_d;
  logic             pend_q, pend_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lfxr_pkg::ST_LOAD;
      pend_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
    end
  end

  always_comb begin
    state_d = state_q;
    pend_d  = pend_q;
    unique case (state_q)
      lfxr_pkg::ST_LOAD: begin
        state_d = lfxr_pkg::ST_FILL;
      end
      lfxr_pkg::ST_FILL: begin
        if (status_i.fill_last) begin
          state_d = pend_q ? lfxr_pkg::ST_RD_A : lfxr_pkg::ST_IDLE;
          pend_d  = 1'b0;
        end
      end
      lfxr_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          if (in_reseed_i) begin
            state_d = lfxr_pkg::ST_LOAD;
            pend_d  = 1'b1;
          end else begin
            state_d = lfxr_pkg::ST_RD_A;
          end
        end
      end
      lfxr_pkg::ST_RD_A: state_d = lfxr_pkg::ST_RD_B;
      lfxr_pkg::ST_RD_B: state_d = lfxr_pkg::ST_RD_C;
      lfxr_pkg::ST_RD_C: state_d = lfxr_pkg::ST_WR;
      lfxr_pkg::ST_WR: begin
        if (status_i.out_free) begin
          state_d = lfxr_pkg::ST_IDLE;
        end
      end
      default: state_d = lfxr_pkg::ST_LOAD;
    endcase
  end

  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    cmd_o.rd_sel = lfxr_pkg::LAG_SEL_A;
    unique case (state_q)
      lfxr_pkg::ST_LOAD: cmd_o.load = 1'b1;
      lfxr_pkg::ST_FILL: cmd_o.fill = 1'b1;
      lfxr_pkg::ST_IDLE: in_ready_o = 1'b1;
      lfxr_pkg::ST_RD_A: cmd_o.rd_sel = lfxr_pkg::LAG_SEL_A;
      lfxr_pkg::ST_RD_B: begin
        cmd_o.rd_sel = lfxr_pkg::LAG_SEL_B;
        cmd_o.cap_a  = 1'b1;
      end
      lfxr_pkg::ST_RD_C: begin
        cmd_o.rd_sel  = lfxr_pkg::LAG_SEL_C;
        cmd_o.cap_sum = 1'b1;
      end
      lfxr_pkg::ST_WR: begin
        cmd_o.rd_sel = lfxr_pkg::LAG_SEL_C;
        cmd_o.draw   = status_i.out_free;
      end
      default: cmd_o.load = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/core/lfxr_dp.sv =====
// Datapath with the seed register, congruential fill, ring RAM and result register.
`default_nettype none

module lfxr_dp (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lfxr_pkg::WORD_W-1:0] cfg_wdata_i,
  input  wire lfxr_pkg::ctrl_cmd_t         cmd_i,
  output lfxr_pkg::dp_status_t             status_o,
  output logic                             out_valid_o,
  input  wire logic                        out_ready_i,
  output logic      [lfxr_pkg::WORD_W-1:0] out_word_o
);

  logic [lfxr_pkg::WORD_W-1:0] seed_q;
  logic [lfxr_pkg::WORD_W-1:0] x_q, x_d;
  logic [lfxr_pkg::IDX_W-1:0]  cnt_q;
  logic [lfxr_pkg::IDX_W-1:0]  idx_q;
  logic [lfxr_pkg::WORD_W-1:0] a_q;
  logic [lfxr_pkg::WORD_W-1:0] sum_q;
  logic [lfxr_pkg::WORD_W-1:0] out_q;
  logic                        out_valid_q;

  logic                        ram_we;
  logic [lfxr_pkg::IDX_W-1:0]  ram_waddr;
  logic [lfxr_pkg::WORD_W-1:0] ram_wdata;
  logic [lfxr_pkg::IDX_W-1:0]  ram_raddr;
  logic [lfxr_pkg::WORD_W-1:0] ram_rdata;

  assign x_d = x_q * lfxr_pkg::LCG_MUL + lfxr_pkg::LCG_ADD;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seed_q <= lfxr_pkg::SEED_RESET;
    end else if (cfg_we_i) begin
      seed_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
        idx_q <= '0;
      end else if (cmd_i.fill) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.draw) begin
        idx_q <= idx_q + 1'b1;
      end
      if (cmd_i.draw) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q <= seed_q;
    end else if (cmd_i.fill) begin
      x_q <= x_d;
    end
    if (cmd_i.cap_a) begin
      a_q <= ram_rdata;
    end
    if (cmd_i.cap_sum) begin
      sum_q <= a_q + ram_rdata;
    end
    if (cmd_i.draw) begin
      out_q <= sum_q ^ ram_rdata;
    end
  end

  always_comb begin
    case (cmd_i.rd_sel)
      lfxr_pkg::LAG_SEL_A: ram_raddr = idx_q - lfxr_pkg::LAG_A;
      lfxr_pkg::LAG_SEL_B: ram_raddr = idx_q - lfxr_pkg::LAG_B;
      lfxr_pkg::LAG_SEL_C: ram_raddr = idx_q - lfxr_pkg::LAG_C;
      default:             ram_raddr = idx_q - lfxr_pkg::LAG_C;
    endcase
  end

  assign ram_we    = cmd_i.fill | cmd_i.draw;
  assign ram_waddr = cmd_i.fill ? cnt_q : idx_q;
  assign ram_wdata = cmd_i.fill ? x_d : sum_q;

  lfxr_ram #(
    .Width(lfxr_pkg::WORD_W),
    .Depth(lfxr_pkg::RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign status_o.fill_last = (cnt_q == '1);
  assign status_o.out_free  = !out_valid_q || out_ready_i;
  assign out_valid_o        = out_valid_q;
  assign out_word_o         = out_q;

endmodule

`default_nettype wire

// ===== rtl/core/lagged_fibonacci_xor_rng.sv =====
// Top level of the lagged Fibonacci xor random word generator.
// Each beat on in_i requests one 32-bit word, delivered as one beat on out_o.
// With reseed set, the ring of 256 words is first refilled from the seed
// register by the congruential sequence and the ring index is cleared.
// The user must write the seed register through cfg_we_i and cfg_wdata_i
// only while idle; the block itself has no check for this. A plain draw
// steps from the input beat through three reads of the ring RAM (ST_RD_A,
// ST_RD_B, ST_RD_C), then the write-back in ST_WR. A new input beat is taken
// only after the previous draw has left ST_WR. A reseed first passes ST_LOAD,
// then makes one RAM write per ring entry. After reset the block fills the
// ring from seed one and keeps in_i.ready low meanwhile.
// The result waits in an output register; the next request is accepted
// while it waits, and that draw holds at its write-back until the
// receiver takes the earlier word.
`default_nettype none

module lagged_fibonacci_xor_rng (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        cfg_we_i,
  input  wire logic [lfxr_pkg::WORD_W-1:0] cfg_wdata_i,
  lfxr_in_if.sink                          in_i,
  lfxr_out_if.source                       out_o
);

  lfxr_pkg::ctrl_cmd_t  cmd;
  lfxr_pkg::dp_status_t status;

  lfxr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_reseed_i(in_i.reseed),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  lfxr_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .status_o   (status),
    .out_valid_o(out_o.valid),
    .out_ready_i(out_o.ready),
    .out_word_o (out_o.random_word)
  );

endmodule

`default_nettype wire

// ===== rtl/core/lfxr_checker.sv =====
// Port-level checker for the generator and its bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module lfxr_checker (
  input wire logic                        clk_i,
  input wire logic                        rst_ni,
  input wire logic                        in_valid_i,
  input wire logic                        in_ready_i,
  input wire logic                        out_valid_i,
  input wire logic                        out_ready_i,
  input wire logic [lfxr_pkg::WORD_W-1:0] out_word_i
);

  logic       in_beat;
  logic       out_beat;
  logic [1:0] open_q;

  assign in_beat  = in_valid_i && in_ready_i;
  assign out_beat = out_valid_i && out_ready_i;

  // Requests accepted whose word has not yet been delivered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q <= '0;
    end else if (in_beat && !out_beat) begin
      open_q <= open_q + 1'b1;
    end else if (out_beat && !in_beat) begin
      open_q <= open_q - 1'b1;
    end
  end

  `ASSERT_NEXT(out_valid_held, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(out_word_held, clk_i, rst_ni, out_valid_i && !out_ready_i, $stable(out_word_i))
  `ASSERT_ALWAYS(no_word_unrequested, clk_i, rst_ni, !out_valid_i || open_q != 2'd0)
  `ASSERT_ALWAYS(open_bounded, clk_i, rst_ni, open_q != 2'd3)

endmodule

bind lagged_fibonacci_xor_rng lfxr_checker u_lfxr_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid_i (in_i.valid),
  .in_ready_i (in_i.ready),
  .out_valid_i(out_o.valid),
  .out_ready_i(out_o.ready),
  .out_word_i (out_o.random_word)
);

`default_nettype wire

// ===== tb/sv/lfxr_draw_checker.sv =====
// Checker that predicts every random word of the generator and compares result beats.
`timescale 1ns / 1ps

module lfxr_draw_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [lfxr_pkg::WORD_W-1:0] cfg_wdata_i,
  lfxr_in_if                          draw_mon,
  lfxr_out_if                         word_mon,
  output int unsigned                 pending_o,
  output int unsigned                 error_count_o
);

  logic [lfxr_pkg::WORD_W-1:0] seed_q;
  logic [lfxr_pkg::WORD_W-1:0] ring_q [lfxr_pkg::RING_DEPTH];
  logic [lfxr_pkg::IDX_W-1:0]  idx_q;
  logic [lfxr_pkg::WORD_W-1:0] expected_words [$];
  int unsigned                 mismatch_count;

  task automatic report_mismatch(input string what);
    $display("%0t ns lfxr_draw_checker: %s", $time, what);
    mismatch_count++;
  endtask

  task automatic refill_ring();
    logic [lfxr_pkg::WORD_W-1:0] x;
    int k;
    x = seed_q;
    for (k = 0; k < lfxr_pkg::RING_DEPTH; k++) begin
      x = x * lfxr_pkg::LCG_MUL + lfxr_pkg::LCG_ADD;
      ring_q[k] = x;
    end
    idx_q = '0;
  endtask

  task automatic lagged_draw(input logic reseed,
                             output logic [lfxr_pkg::WORD_W-1:0] word);
    logic [lfxr_pkg::IDX_W-1:0]  ia;
    logic [lfxr_pkg::IDX_W-1:0]  ib;
    logic [lfxr_pkg::IDX_W-1:0]  ic;
    logic [lfxr_pkg::WORD_W-1:0] sum;
    if (reseed) begin
      refill_ring();
    end
    ia = idx_q - lfxr_pkg::LAG_A;
    ib = idx_q - lfxr_pkg::LAG_B;
    ic = idx_q - lfxr_pkg::LAG_C;
    sum = ring_q[ia] + ring_q[ib];
    ring_q[idx_q] = sum;
    word = sum ^ ring_q[ic];
    idx_q = idx_q + 1'b1;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [lfxr_pkg::WORD_W-1:0] want;
    logic [lfxr_pkg::WORD_W-1:0] drawn;
    if (!rst_ni) begin
      seed_q = lfxr_pkg::SEED_RESET;
      refill_ring();
      expected_words.delete();
      mismatch_count = 0;
    end else begin
      if (word_mon.valid && word_mon.ready) begin
        if (expected_words.size() == 0) begin
          report_mismatch($sformatf("result beat %08h with no word expected",
                                    word_mon.random_word));
        end else begin
          want = expected_words.pop_front();
          if (word_mon.random_word !== want) begin
            report_mismatch($sformatf("random_word %08h, expected %08h",
                                      word_mon.random_word, want));
          end
        end
      end
      if (draw_mon.valid && draw_mon.ready) begin
        lagged_draw(draw_mon.reseed, drawn);
        expected_words.push_back(drawn);
      end
      if (cfg_we_i) begin
        seed_q = cfg_wdata_i;
      end
    end
    pending_o <= expected_words.size();
    error_count_o <= mismatch_count;
  end

endmodule

// ===== tb/sv/tb_lagged_fibonacci_xor_rng.sv =====
// Testbench top that drives draw requests and seed writes and gives the verdict.
`timescale 1ns / 1ps

module tb_lagged_fibonacci_xor_rng;

  localparam int unsigned CLK_PERIOD   = 10;
  localparam int unsigned RESET_CYCLES = 10;
  localparam int unsigned DRAIN_CYCLES = 40;
  localparam int unsigned CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned HOLD_AFTER   = 120;
  localparam int unsigned HOLD_CYCLES  = 150;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_CHOPPY,
    RX_SLUGGISH
  } rx_mode_e;

  logic                        clk_i = 1'b0;
  logic                        rst_ni;
  logic                        cfg_we;
  logic [lfxr_pkg::WORD_W-1:0] cfg_wdata;
  int unsigned                 pending_words;
  int unsigned                 error_count;
  int unsigned                 cycle_count = 0;

  int unsigned                 words_taken = 0;
  int unsigned                 rx_cycle = 0;
  int unsigned                 hold_left = 0;
  logic                        hold_done = 1'b0;
  rx_mode_e                    rx_mode = RX_OPEN;

  lfxr_in_if  draw_req_if ();
  lfxr_out_if word_if ();

  lagged_fibonacci_xor_rng u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (draw_req_if),
    .out_o       (word_if)
  );

  lfxr_draw_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_wdata_i   (cfg_wdata),
    .draw_mon      (draw_req_if),
    .word_mon      (word_if),
    .pending_o     (pending_words),
    .error_count_o (error_count)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_lagged_fibonacci_xor_rng: FAIL");
      $finish;
    end
  end

  // The receiver changes its manner at random and holds off once for a long stretch.
  always @(posedge clk_i) begin
    if (word_if.valid && word_if.ready) begin
      words_taken = words_taken + 1;
    end
    if (!hold_done && words_taken >= HOLD_AFTER) begin
      hold_left = HOLD_CYCLES;
      hold_done = 1'b1;
    end
    if (rx_cycle % 64 == 0) begin
      rx_mode = rx_mode_e'($urandom_range(RX_OPEN, RX_SLUGGISH));
    end
    rx_cycle = rx_cycle + 1;
    if (hold_left != 0) begin
      hold_left = hold_left - 1;
      word_if.ready <= 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN: begin
          word_if.ready <= 1'b1;
        end
        RX_CHOPPY: begin
          word_if.ready <= 1'($urandom_range(0, 1));
        end
        default: begin
          word_if.ready <= ($urandom_range(0, 3) == 0);
        end
      endcase
    end
  end

  task automatic send_draw(input logic reseed);
    draw_req_if.valid <= 1'b1;
    draw_req_if.reseed <= reseed;
    @(posedge clk_i);
    while (!draw_req_if.ready) @(posedge clk_i);
  endtask

  task automatic drain_words();
    draw_req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_words != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_seed(input logic [lfxr_pkg::WORD_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
  endtask

  // The first beat of a phase always reseeds so that the new seed takes effect.
  task automatic run_phase(input int unsigned n_items, input int unsigned reseed_pct);
    int unsigned burst_left;
    int unsigned gap;
    int unsigned n;
    burst_left = $urandom_range(1, 12);
    for (n = 0; n < n_items; n++) begin
      send_draw(n == 0 || $urandom_range(0, 99) < reseed_pct);
      burst_left = burst_left - 1;
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap != 0) begin
          draw_req_if.valid <= 1'b0;
          repeat (gap) @(posedge clk_i);
        end
        burst_left = $urandom_range(1, 12);
      end
    end
  endtask

  initial begin
    rst_ni <= 1'b0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    draw_req_if.valid <= 1'b0;
    draw_req_if.reseed <= 1'b0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Draws from the ring filled at reset.
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b0);
    drain_words();

    // A seed write alone leaves the ring as it is until a reseed beat.
    write_seed('0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b1);
    drain_words();

    write_seed('1);
    send_draw(1'b0);
    send_draw(1'b1);
    send_draw(1'b0);
    send_draw(1'b0);
    drain_words();

    write_seed(lfxr_pkg::SEED_RESET);
    send_draw(1'b1);
    send_draw(1'b0);
    drain_words();

    // A long phase with a reseed only on its first beat lets the ring index wrap.
    write_seed($urandom);
    run_phase(300, 0);
    drain_words();

    write_seed($urandom);
    run_phase(200, 3);
    drain_words();

    write_seed(32'h8000_0000);
    run_phase(150, 6);
    drain_words();

    write_seed($urandom);
    run_phase(140, 2);
    drain_words();

    if (error_count == 0) begin
      $display("tb_lagged_fibonacci_xor_rng: PASS");
    end else begin
      $display("tb_lagged_fibonacci_xor_rng: FAIL");
    end
    $finish;
  end

endmodule
